[sv/html_tag_strip_entity_decoder_unit_assert.svh]
// Assertion macros for the tag stripper.
`ifndef HTML_TAG_STRIP_ENTITY_DECODER_UNIT_ASSERT_SVH
`define HTML_TAG_STRIP_ENTITY_DECODER_UNIT_ASSERT_SVH
// Same-cycle implication.
`define HTSED_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htsed assertion failed");
// Next-cycle implication.
`define HTSED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htsed assertion failed");
`endif

[sv/htsed_pkg.sv]
`timescale 1ns / 1ps
package htsed_pkg;

  localparam int PENDING_DEPTH_DEF = 32;
  localparam int CNT_W = 9;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_AMP = 2'd1;
  localparam logic [1:0] KIND_NAMED = 2'd2;
  localparam logic [1:0] KIND_NUMERIC = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] flush_cnt;
    logic             has_byte;
    logic [7:0]       data;
    logic             last;
  } op_t;

  // Lowercase name, right-justified, first letter highest.
  function automatic logic [7:0] ent_code(input logic [47:0] nm);
    logic [7:0] c;
    case (nm)
      48'("lt"): c = "<";
      48'("gt"): c = ">";
      48'("amp"): c = "#";
      48'("quot"): c = "\"";
      48'("nbsp"): c = " ";
      48'("iexcl"): c = "!";
      48'("cent"): c = " ";
      48'("pound"): c = " ";
      48'("curren"): c = " ";
      48'("yen"): c = " ";
      48'("brvbar"): c = "|";
      48'("sect"): c = " ";
      48'("uml"): c = " ";
      48'("copy"): c = " ";
      48'("ordf"): c = " ";
      48'("laquo"): c = " ";
      48'("not"): c = " ";
      48'("shy"): c = " ";
      48'("reg"): c = " ";
      48'("macr"): c = " ";
      48'("deg"): c = " ";
      48'("plusmn"): c = "+";
      48'("acute"): c = "^";
      48'("micro"): c = " ";
      48'("para"): c = " ";
      48'("middot"): c = " ";
      48'("cedil"): c = "c";
      48'("ordm"): c = " ";
      48'("raquo"): c = " ";
      48'("iquest"): c = " ";
      48'("agrave"): c = "a";
      48'("aacute"): c = "a";
      48'("acirc"): c = "a";
      48'("atilde"): c = "a";
      48'("auml"): c = "a";
      48'("aring"): c = "a";
      48'("aelig"): c = "a";
      48'("ccedil"): c = "c";
      48'("egrave"): c = "e";
      48'("eacute"): c = "e";
      48'("ecirc"): c = "e";
      48'("euml"): c = "e";
      48'("igrave"): c = "i";
      48'("iacute"): c = "i";
      48'("icirc"): c = "i";
      48'("iuml"): c = "i";
      48'("eth"): c = " ";
      48'("ntilde"): c = "n";
      48'("ograve"): c = "o";
      48'("oacute"): c = "o";
      48'("ocirc"): c = "o";
      48'("otilde"): c = "o";
      48'("ouml"): c = "o";
      48'("times"): c = "x";
      48'("oslash"): c = "o";
      48'("ugrave"): c = "u";
      48'("uacute"): c = "u";
      48'("ucirc"): c = "u";
      48'("uuml"): c = "u";
      48'("yacute"): c = "y";
      48'("thorn"): c = " ";
      48'("szlig"): c = "s";
      48'("divide"): c = "/";
      48'("yuml"): c = "y";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

[sv/htsed_ram.sv]
`timescale 1ns / 1ps
module htsed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[sv/htsed_front.sv]
`timescale 1ns / 1ps
module htsed_front #(
  parameter int PENDING_DEPTH = htsed_pkg::PENDING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_text_byte,
  input  logic                             in_end_of_text,
  output logic                             push,
  output htsed_pkg::op_t                   push_op,
  input  logic                             q_ready,
  input  logic                             flush_done,
  output logic                             wr_en,
  output logic [$clog2(PENDING_DEPTH)-1:0] wr_addr,
  output logic [7:0]                       wr_data
);

  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int AW = $clog2(PENDING_DEPTH);
  localparam int NW = htsed_pkg::CNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);

  logic          tag_r, tag_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    num_r, num_nxt;
  logic          nz_r, nz_nxt;
  logic          ended_r, ended_nxt;
  logic [47:0]   name_r, name_nxt;
  logic          long_r, long_nxt;
  logic          busy_r, busy_nxt;

  logic          accept, letter, digit, grow, fail, plain, fin;
  logic [7:0]    b, d, code;
  logic [CW-1:0] fl;
  logic          hb;
  logic [7:0]    bt;

  assign in_ready = !busy_r && q_ready;
  assign accept = in_valid && in_ready;
  assign b = in_text_byte;
  assign letter = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  assign digit = (b >= "0" && b <= "9");
  assign d = b - 8'h30;
  assign code = long_r ? 8'd0 : htsed_pkg::ent_code(name_r);

  always_comb begin
    tag_nxt = tag_r;
    kind_nxt = kind_r;
    cnt_nxt = cnt_r;
    num_nxt = num_r;
    nz_nxt = nz_r;
    ended_nxt = ended_r;
    name_nxt = name_r;
    long_nxt = long_r;
    fl = '0;
    hb = 1'b0;
    bt = b;
    wr_en = 1'b0;
    wr_addr = cnt_r[AW-1:0];
    wr_data = b;
    grow = 1'b0;
    fail = 1'b0;
    plain = 1'b0;
    fin = 1'b0;
    if (accept && !ended_r) begin
      fin = (b == 8'd0) || in_end_of_text;
      if (b != 8'd0) begin
        case (kind_r)
          htsed_pkg::KIND_NONE: plain = 1'b1;
          htsed_pkg::KIND_AMP: begin
            if (letter) begin
              kind_nxt = htsed_pkg::KIND_NAMED;
              grow = 1'b1;
            end else if (b == "#") begin
              kind_nxt = htsed_pkg::KIND_NUMERIC;
              grow = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          htsed_pkg::KIND_NAMED: begin
            if (letter) begin
              grow = 1'b1;
            end else if (b == ";") begin
              hb = (code != 8'd0);
              bt = code;
              kind_nxt = htsed_pkg::KIND_NONE;
              cnt_nxt = '0;
            end else begin
              fail = 1'b1;
            end
          end
          default: begin
            if (digit) begin
              grow = 1'b1;
            end else if (b == ";" && cnt_r >= CW'(3)) begin
              hb = nz_r;
              bt = num_r;
              kind_nxt = htsed_pkg::KIND_NONE;
              cnt_nxt = '0;
            end else begin
              fail = 1'b1;
            end
          end
        endcase
        if (grow) begin
          if (cnt_r < DEPTH_C) begin
            wr_en = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            if (kind_r == htsed_pkg::KIND_NUMERIC) begin
              num_nxt = (num_r << 3) + (num_r << 1) + d;
              nz_nxt = nz_r || (d != 8'd0);
            end else if (letter) begin
              name_nxt = {name_r[39:0], b | 8'h20};
              long_nxt = long_r || (cnt_r >= CW'(7));
            end
          end else begin
            kind_nxt = kind_r;
            fail = 1'b1;
          end
        end
        if (fail) begin
          fl = cnt_r;
          kind_nxt = htsed_pkg::KIND_NONE;
          cnt_nxt = '0;
          plain = 1'b1;
        end
        if (plain) begin
          if (tag_r) begin
            if (b == ">") begin
              tag_nxt = 1'b0;
            end
          end else if (b == "<") begin
            tag_nxt = 1'b1;
          end else if (b == "&") begin
            kind_nxt = htsed_pkg::KIND_AMP;
            cnt_nxt = CW'(1);
            wr_en = 1'b1;
            wr_addr = '0;
          end else begin
            hb = 1'b1;
            bt = b;
          end
        end
        if (kind_nxt == htsed_pkg::KIND_NONE || kind_nxt == htsed_pkg::KIND_AMP) begin
          if (kind_nxt == htsed_pkg::KIND_AMP || kind_r != kind_nxt) begin
            num_nxt = '0;
            nz_nxt = 1'b0;
            name_nxt = '0;
            long_nxt = 1'b0;
          end
        end
      end
      if (fin) begin
        if (fail) begin
          if (cnt_nxt != '0) begin
            hb = 1'b1;
            bt = "&";
          end
        end else begin
          fl = cnt_nxt;
        end
        ended_nxt = 1'b1;
        kind_nxt = htsed_pkg::KIND_NONE;
        cnt_nxt = '0;
      end
    end
  end

  assign push = (fl != '0) || hb || fin;
  assign push_op = '{flush_cnt: NW'(fl), has_byte: hb, data: bt, last: fin};

  always_comb begin
    if (busy_r) begin
      busy_nxt = !flush_done;
    end else begin
      busy_nxt = push && (fl != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= 1'b0;
      kind_r <= htsed_pkg::KIND_NONE;
      cnt_r <= '0;
      num_r <= '0;
      nz_r <= 1'b0;
      ended_r <= 1'b0;
      name_r <= '0;
      long_r <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      tag_r <= tag_nxt;
      kind_r <= kind_nxt;
      cnt_r <= cnt_nxt;
      num_r <= num_nxt;
      nz_r <= nz_nxt;
      ended_r <= ended_nxt;
      name_r <= name_nxt;
      long_r <= long_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

[sv/htsed_queue.sv]
`timescale 1ns / 1ps
module htsed_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  htsed_pkg::op_t push_op,
  output logic           q_ready,
  input  logic           pop,
  output logic           q_valid,
  output htsed_pkg::op_t q_op
);

  htsed_pkg::op_t ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] n_r, n_nxt;

  assign q_ready = (n_r != 2'd2);
  assign q_valid = (n_r != 2'd0);
  assign q_op = ent_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    n_nxt = n_r;
    if (push && q_ready) begin
      wp_nxt = !wp_r;
      n_nxt = n_nxt + 2'd1;
    end
    if (pop && q_valid) begin
      rp_nxt = !rp_r;
      n_nxt = n_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && q_ready) begin
      ent_r[wp_r] <= push_op;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      n_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      n_r <= n_nxt;
    end
  end

endmodule

[sv/htsed_back.sv]
`timescale 1ns / 1ps
module htsed_back #(
  parameter int PENDING_DEPTH = htsed_pkg::PENDING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  htsed_pkg::op_t                   q_op,
  output logic                             pop,
  output logic                             flush_done,
  output logic [$clog2(PENDING_DEPTH)-1:0] rd_addr,
  input  logic [7:0]                       rd_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_byte,
  output logic                             out_byte_valid,
  output logic                             out_end_marker
);

  localparam int AW = $clog2(PENDING_DEPTH);
  localparam int NW = htsed_pkg::CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_NEXT = 4'b0010,
    ST_RD   = 4'b0100,
    ST_SHOW = 4'b1000
  } st_t;

  st_t         st_r, st_nxt;
  logic [NW-1:0] idx_r, idx_nxt, ccnt_r, ccnt_nxt;
  logic        chas_r, chas_nxt, cval_r, cval_nxt, cend_r, cend_nxt;
  logic [7:0]  cbyte_r, cbyte_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        ov_r, ov_nxt, oe_r, oe_nxt;

  assign rd_addr = idx_r[AW-1:0];
  assign out_valid = (st_r == ST_SHOW);
  assign out_byte = ob_r;
  assign out_byte_valid = ov_r;
  assign out_end_marker = oe_r;

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    ccnt_nxt = ccnt_r;
    chas_nxt = chas_r;
    cval_nxt = cval_r;
    cend_nxt = cend_r;
    cbyte_nxt = cbyte_r;
    ob_nxt = ob_r;
    ov_nxt = ov_r;
    oe_nxt = oe_r;
    pop = 1'b0;
    flush_done = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          idx_nxt = '0;
          ccnt_nxt = q_op.flush_cnt;
          cend_nxt = q_op.last;
          // bare end marker when nothing else comes out
          if (q_op.last && q_op.flush_cnt == '0 && !q_op.has_byte) begin
            chas_nxt = 1'b1;
            cval_nxt = 1'b0;
            cbyte_nxt = 8'd0;
          end else begin
            chas_nxt = q_op.has_byte;
            cval_nxt = 1'b1;
            cbyte_nxt = q_op.data;
          end
          st_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (idx_r < ccnt_r) begin
          st_nxt = ST_RD;
        end else if (chas_r) begin
          ob_nxt = cbyte_r;
          ov_nxt = cval_r;
          oe_nxt = cend_r;
          chas_nxt = 1'b0;
          st_nxt = ST_SHOW;
        end else begin
          flush_done = (ccnt_r != '0);
          st_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        ob_nxt = rd_data;
        ov_nxt = 1'b1;
        oe_nxt = cend_r && !chas_r && (idx_r + NW'(1) == ccnt_r);
        idx_nxt = idx_r + NW'(1);
        st_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) begin
          st_nxt = ST_NEXT;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    ccnt_r <= ccnt_nxt;
    chas_r <= chas_nxt;
    cval_r <= cval_nxt;
    cend_r <= cend_nxt;
    cbyte_r <= cbyte_nxt;
    ob_r <= ob_nxt;
    ov_r <= ov_nxt;
    oe_r <= oe_nxt;
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

[sv/html_tag_strip_entity_decoder_unit.sv]
`timescale 1ns / 1ps
// Tag stripper and entity decoder.
// Input channel (in_valid/in_ready): one text byte per beat with an end flag;
// a zero byte or the end flag closes the text, after which beats are taken
// and dropped until reset.
// Output channel (out_valid/out_ready): cleaned bytes, one per beat; the last
// beat of the text has out_end_marker set, and a bare marker has
// out_byte_valid low.
// The front classifies each byte in the cycle it is taken and posts at most
// one op to a two-entry queue; the back expands ops into beats.
// In the back a plain byte passes through the idle, next and show states; a
// failed entity flush of n bytes reads each pending byte through next, read
// and show, the read of the pending buffer RAM being registered, plus a show
// for the breaking byte when it is emitted. Input is held off while a flush is
// outstanding or the queue is full.
// Reset clears tag, entity and end state; the pending buffer is not cleared.
// A stalled receiver holds the output beat and backs up through the queue.
module html_tag_strip_entity_decoder_unit #(
  parameter int PENDING_DEPTH = htsed_pkg::PENDING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_end_marker
);

  localparam int AW = $clog2(PENDING_DEPTH);

  logic           push, q_ready, pop, q_valid, flush_done, wr_en;
  htsed_pkg::op_t push_op, q_op;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [7:0]     wr_data, rd_data;

  htsed_front #(.PENDING_DEPTH(PENDING_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_text_byte(in_text_byte), .in_end_of_text(in_end_of_text),
    .push(push), .push_op(push_op), .q_ready(q_ready), .flush_done(flush_done),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  htsed_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_op(push_op), .q_ready(q_ready),
    .pop(pop), .q_valid(q_valid), .q_op(q_op)
  );

  htsed_ram #(.WIDTH(8), .DEPTH(PENDING_DEPTH)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  htsed_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_op(q_op), .pop(pop),
    .flush_done(flush_done), .rd_addr(rd_addr), .rd_data(rd_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_byte_valid(out_byte_valid), .out_end_marker(out_end_marker)
  );

endmodule

[sv/htsed_checker.sv]
`timescale 1ns / 1ps
`include "html_tag_strip_entity_decoder_unit_assert.svh"
module htsed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_end_marker
);

  `HTSED_ASSERT(a_bare_is_end, out_valid && !out_byte_valid, out_end_marker)
  `HTSED_ASSERT(a_bare_is_zero, out_valid && !out_byte_valid, out_byte == 8'd0)
  `HTSED_ASSERT_NEXT(a_nothing_after_end, out_valid && out_ready && out_end_marker, !out_valid)
  `HTSED_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte))
  `HTSED_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid)

endmodule

bind html_tag_strip_entity_decoder_unit htsed_checker u_htsed_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
  .out_byte_valid(out_byte_valid), .out_end_marker(out_end_marker)
);
